/* hdl/lob_pkg.sv */
// Package with shared types, codes and the priority compare of the order book.
package lob_pkg;

  localparam int BOOK_DEPTH = 32;
  localparam int ROT_W      = $clog2(BOOK_DEPTH);

  typedef enum logic [2:0] {
    KIND_FILL   = 3'd0,
    KIND_RESTED = 3'd1,
    KIND_REJECT = 3'd2,
    KIND_LEVEL  = 3'd3,
    KIND_EMPTY  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_REST,
    ST_QRY,
    ST_QEND
  } state_e;

  typedef enum logic [2:0] {
    CH_HOLD,
    CH_POP,
    CH_ROT,
    CH_SETQ,
    CH_INS
  } chain_op_e;

  typedef enum logic [1:0] {
    C_HOLD,
    C_SHL,
    C_SETQ,
    C_INS
  } cell_op_e;

  typedef struct packed {
    logic        func;
    logic        side;
    logic [31:0] limit_price;
    logic [31:0] order_qty;
    logic [47:0] arrival_time;
    logic [5:0]  level_count;
  } lob_in_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] taker_id;
    logic [31:0] maker_id;
    logic [31:0] trade_price;
    logic [39:0] trade_qty;
    logic        last;
  } lob_out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] price;
    logic [31:0] qty;
    logic [47:0] time_stamp;
    logic [31:0] id;
  } entry_t;

  typedef struct packed {
    chain_op_e   op;
    entry_t      ins;
    logic [31:0] setq;
  } chain_cmd_t;

  // True if entry a ranks strictly ahead of entry b on the given side
  function automatic logic entry_ahead(logic is_bid, entry_t a, entry_t b);
    logic r;
    if (a.price != b.price) begin
      r = is_bid ? (a.price > b.price) : (a.price < b.price);
    end else if (a.time_stamp != b.time_stamp) begin
      r = a.time_stamp < b.time_stamp;
    end else begin
      r = a.id < b.id;
    end
    return r;
  endfunction

endpackage

/* hdl/lob_cell.sv */
// One cell of a sorted book chain: holds one resting order.
module lob_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lob_pkg::cell_op_e   op_i,
  input  logic                is_bid_i,
  input  lob_pkg::entry_t     new_i,
  input  lob_pkg::entry_t     left_i,
  input  lob_pkg::entry_t     right_i,
  input  logic [31:0]         setq_i,
  input  logic                ins_left_i,
  output logic                ins_o,
  output lob_pkg::entry_t     ent_o
);

  lob_pkg::entry_t ent_q, ent_d;

  // new order belongs here or earlier
  assign ins_o = !ent_q.valid || lob_pkg::entry_ahead(is_bid_i, new_i, ent_q);

  always_comb begin
    ent_d = ent_q;
    case (op_i)
      lob_pkg::C_SHL:  ent_d = right_i;
      lob_pkg::C_SETQ: ent_d.qty = setq_i;
      lob_pkg::C_INS: begin
        if (ins_left_i) begin
          ent_d = left_i;
        end else if (ins_o) begin
          ent_d = new_i;
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  // cell register, empty after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

/* hdl/lob_chain.sv */
// One side of the book: a row of cells kept in priority order, best at the head.
module lob_chain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                is_bid_i,
  input  lob_pkg::chain_cmd_t cmd_i,
  output lob_pkg::entry_t     head_o,
  output logic                full_o
);

  lob_pkg::entry_t ent   [lob_pkg::BOOK_DEPTH];
  logic            ins   [lob_pkg::BOOK_DEPTH];
  lob_pkg::entry_t tail_feed;
  lob_pkg::cell_op_e cop, head_op;

  // map side command to cell operation
  always_comb begin
    case (cmd_i.op)
      lob_pkg::CH_POP, lob_pkg::CH_ROT: cop = lob_pkg::C_SHL;
      lob_pkg::CH_INS:                  cop = lob_pkg::C_INS;
      default:                          cop = lob_pkg::C_HOLD;
    endcase
    head_op = (cmd_i.op == lob_pkg::CH_SETQ) ? lob_pkg::C_SETQ : cop;
  end

  // rotation feeds the head back into the tail, a pop feeds an empty cell
  always_comb begin
    tail_feed = '0;
    if (cmd_i.op == lob_pkg::CH_ROT) begin
      tail_feed = ent[0];
    end
  end

  for (genvar i = 0; i < lob_pkg::BOOK_DEPTH; i++) begin : g_cell
    lob_pkg::entry_t lft, rgt;
    logic            ins_l;
    if (i == 0) begin : g_head
      assign lft   = '0;
      assign ins_l = 1'b0;
    end else begin : g_body
      assign lft   = ent[i-1];
      assign ins_l = ins[i-1];
    end
    if (i == lob_pkg::BOOK_DEPTH - 1) begin : g_tail
      assign rgt = tail_feed;
    end else begin : g_mid
      assign rgt = ent[i+1];
    end

    lob_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .op_i       ((i == 0) ? head_op : cop),
      .is_bid_i   (is_bid_i),
      .new_i      (cmd_i.ins),
      .left_i     (lft),
      .right_i    (rgt),
      .setq_i     (cmd_i.setq),
      .ins_left_i (ins_l),
      .ins_o      (ins[i]),
      .ent_o      (ent[i])
    );
  end

  assign head_o = ent[0];
  assign full_o = ent[lob_pkg::BOOK_DEPTH-1].valid;

endmodule

/* hdl/limit_order_book_matcher.sv */
// Top level of the order book matcher: sequencer, id counter and result register.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  in_item_i  (lob_in_t)
//   out      output     out_valid_o/out_ready_i out_item_o (lob_out_t)
//
// An order is accepted, then filled one fill per match step (the best opposite
// order is always at the chain head); a remainder takes one more match step to
// see that nothing crosses and one step to rest or reject it.
// A depth query rotates the queried chain once.
// A zero quantity order goes straight back to idle. Reset empties both books at once.
// A result waiting in the output register stalls every step that writes a
// result and every rotation step of a depth query; a match step that finds
// nothing crossing goes on.
module limit_order_book_matcher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lob_pkg::lob_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lob_pkg::lob_out_t out_item_o
);

  lob_pkg::state_e     state_q, state_d;
  lob_pkg::lob_in_t    req_q, req_d;
  logic [31:0]         next_id_q, next_id_d;
  logic [31:0]         taker_q, taker_d;
  logic [31:0]         left_q, left_d;
  logic [lob_pkg::ROT_W-1:0] cnt_q, cnt_d;
  logic [5:0]          nlev_q, nlev_d;
  logic                have_q, have_d;
  logic [31:0]         cur_q, cur_d;
  logic [39:0]         sum_q, sum_d;
  logic                out_valid_q, out_valid_d;
  lob_pkg::lob_out_t   out_q, out_d;

  lob_pkg::chain_cmd_t bid_cmd, ask_cmd, opp_cmd, own_cmd;
  lob_pkg::entry_t     bid_head, ask_head, opp_head, own_head;
  logic                bid_full, ask_full, own_full;
  logic                out_free, crosses;
  logic [31:0]         fill;
  lob_pkg::entry_t     new_ent;

  lob_chain u_bid (
    .clk_i (clk_i), .rst_ni (rst_ni), .is_bid_i (1'b1),
    .cmd_i (bid_cmd), .head_o (bid_head), .full_o (bid_full)
  );

  lob_chain u_ask (
    .clk_i (clk_i), .rst_ni (rst_ni), .is_bid_i (1'b0),
    .cmd_i (ask_cmd), .head_o (ask_head), .full_o (ask_full)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign opp_head = req_q.side ? bid_head : ask_head;
  assign own_head = req_q.side ? ask_head : bid_head;
  assign own_full = req_q.side ? ask_full : bid_full;
  assign crosses  = req_q.side ? (opp_head.price >= req_q.limit_price)
                               : (opp_head.price <= req_q.limit_price);
  assign fill     = (opp_head.qty < left_q) ? opp_head.qty : left_q;

  always_comb begin
    new_ent.valid      = 1'b1;
    new_ent.price      = req_q.limit_price;
    new_ent.qty        = left_q;
    new_ent.time_stamp = req_q.arrival_time;
    new_ent.id         = taker_q;
  end

  // route commands to the chains by side
  always_comb begin
    bid_cmd = req_q.side ? opp_cmd : own_cmd;
    ask_cmd = req_q.side ? own_cmd : opp_cmd;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    next_id_d   = next_id_q;
    taker_d     = taker_q;
    left_d      = left_q;
    cnt_d       = cnt_q;
    nlev_d      = nlev_q;
    have_d      = have_q;
    cur_d       = cur_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    opp_cmd     = '{op: lob_pkg::CH_HOLD, ins: new_ent, setq: opp_head.qty - fill};
    own_cmd     = '{op: lob_pkg::CH_HOLD, ins: new_ent, setq: '0};
    in_ready_o  = 1'b0;

    unique case (state_q)
      lob_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d  = in_item_i;
          cnt_d  = '0;
          nlev_d = '0;
          have_d = 1'b0;
          cur_d  = '0;
          sum_d  = '0;
          if (!in_item_i.func) begin
            taker_d   = next_id_q;
            next_id_d = next_id_q + 32'd1;
            left_d    = in_item_i.order_qty;
            state_d   = (in_item_i.order_qty == '0) ? lob_pkg::ST_IDLE
                                                    : lob_pkg::ST_MATCH;
          end else begin
            state_d = lob_pkg::ST_QRY;
          end
        end
      end

      // one fill per cycle against the opposite head, while the output register is free
      lob_pkg::ST_MATCH: begin
        if (!(opp_head.valid && crosses)) begin
          state_d = lob_pkg::ST_REST;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{kind: lob_pkg::KIND_FILL, taker_id: taker_q,
                    maker_id: opp_head.id, trade_price: opp_head.price,
                    trade_qty: {8'd0, fill}, last: (fill == left_q)};
          opp_cmd.op = (opp_head.qty == fill) ? lob_pkg::CH_POP : lob_pkg::CH_SETQ;
          left_d = left_q - fill;
          if (fill == left_q) begin
            state_d = lob_pkg::ST_IDLE;
          end
        end
      end

      // rest the remainder or reject it
      lob_pkg::ST_REST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{kind: own_full ? lob_pkg::KIND_REJECT : lob_pkg::KIND_RESTED,
                    taker_id: taker_q, maker_id: '0,
                    trade_price: req_q.limit_price,
                    trade_qty: {8'd0, left_q}, last: 1'b1};
          if (!own_full) begin
            own_cmd.op = lob_pkg::CH_INS;
          end
          state_d = lob_pkg::ST_IDLE;
        end
      end

      // rotate the queried chain once, summing runs of equal price
      lob_pkg::ST_QRY: begin
        if (out_free) begin
          own_cmd.op = lob_pkg::CH_ROT;
          if (own_head.valid && (nlev_q < req_q.level_count)) begin
            if (have_q && (own_head.price == cur_q)) begin
              sum_d = sum_q + {8'd0, own_head.qty};
            end else if (have_q) begin
              out_valid_d = 1'b1;
              out_d = '{kind: lob_pkg::KIND_LEVEL, taker_id: '0, maker_id: '0,
                        trade_price: cur_q, trade_qty: sum_q,
                        last: ((nlev_q + 6'd1) == req_q.level_count)};
              nlev_d = nlev_q + 6'd1;
              have_d = (nlev_q + 6'd1) < req_q.level_count;
              cur_d  = own_head.price;
              sum_d  = {8'd0, own_head.qty};
            end else begin
              have_d = 1'b1;
              cur_d  = own_head.price;
              sum_d  = {8'd0, own_head.qty};
            end
          end
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == lob_pkg::ROT_W'(lob_pkg::BOOK_DEPTH - 1)) begin
            state_d = lob_pkg::ST_QEND;
          end
        end
      end

      // flush the pending level, or report an empty answer
      lob_pkg::ST_QEND: begin
        if (out_free) begin
          if (have_q) begin
            out_valid_d = 1'b1;
            out_d = '{kind: lob_pkg::KIND_LEVEL, taker_id: '0, maker_id: '0,
                      trade_price: cur_q, trade_qty: sum_q, last: 1'b1};
          end else if (nlev_q == '0) begin
            out_valid_d = 1'b1;
            out_d = '{kind: lob_pkg::KIND_EMPTY, taker_id: '0, maker_id: '0,
                      trade_price: '0, trade_qty: '0, last: 1'b1};
          end
          state_d = lob_pkg::ST_IDLE;
        end
      end

      default: state_d = lob_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lob_pkg::ST_IDLE;
      next_id_q   <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      nlev_q      <= '0;
      have_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_id_q   <= next_id_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      nlev_q      <= nlev_d;
      have_q      <= have_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    taker_q <= taker_d;
    left_q  <= left_d;
    cur_q   <= cur_d;
    sum_q   <= sum_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // books never stay crossed between items
  a_uncrossed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lob_pkg::ST_IDLE && bid_head.valid && ask_head.valid)
      |-> (bid_head.price < ask_head.price))
    else $error("bid and ask books crossed at idle");

  // every accepted order consumes one id
  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !in_item_i.func)
      |=> (next_id_q == $past(next_id_q) + 32'd1))
    else $error("order id not advanced by one");

  // zero quantity order finishes at once
  a_zero_qty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !in_item_i.func && in_item_i.order_qty == '0)
      |=> (state_q == lob_pkg::ST_IDLE))
    else $error("zero quantity order did not return to idle");

  // between items a full side keeps its head
  a_full_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lob_pkg::ST_IDLE)
      |-> ((!bid_full || bid_head.valid) && (!ask_full || ask_head.valid)))
    else $error("chain full flag without valid head");
`endif

endmodule

/* tb/limit_order_book_matcher_tb.sv */
// Testbench of the order book matcher: directed table, random orders and queries, in-bench book model.
module limit_order_book_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NDIR = 20;
  localparam int NRAND = 195;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  lob_pkg::lob_in_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  lob_pkg::lob_out_t out_item_o;

  limit_order_book_matcher u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predicted book: one entry array per side
  lob_pkg::entry_t book [2][lob_pkg::BOOK_DEPTH];
  logic [31:0] id_next;
  lob_pkg::lob_out_t fills_due [$];
  int mismatches = 0;
  int cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  function automatic bit ranks_ahead(bit bid, lob_pkg::entry_t a, lob_pkg::entry_t b);
    if (a.price != b.price) return bid ? (a.price > b.price) : (a.price < b.price);
    if (a.time_stamp != b.time_stamp) return a.time_stamp < b.time_stamp;
    return a.id < b.id;
  endfunction

  function automatic void push_result(lob_pkg::kind_e k, logic [31:0] tk, logic [31:0] mk,
                                      logic [31:0] pr, logic [39:0] q);
    lob_pkg::lob_out_t r;
    r.kind = k; r.taker_id = tk; r.maker_id = mk;
    r.trade_price = pr; r.trade_qty = q; r.last = 1'b0;
    fills_due = {fills_due, r};
  endfunction

  // Work out the results of one accepted item and update the book
  function automatic void book_apply(lob_pkg::lob_in_t it);
    int n0, b, slot, cnt;
    logic [31:0] left, fill, lvl, prev;
    logic [39:0] sum;
    bit found, have_prev, crossing;
    int os;
    n0 = fills_due.size();
    if (it.func == 1'b0) begin
      os = it.side ^ 1;
      left = it.order_qty;
      id_next = id_next + 1;
      while (left != 0) begin
        b = -1;
        for (int i = 0; i < lob_pkg::BOOK_DEPTH; i++)
          if (book[os][i].valid && (b < 0 || ranks_ahead(os == 0, book[os][i], book[os][b])))
            b = i;
        if (b < 0) break;
        crossing = it.side == 0 ? (book[os][b].price <= it.limit_price)
                                : (book[os][b].price >= it.limit_price);
        if (!crossing) break;
        fill = book[os][b].qty < left ? book[os][b].qty : left;
        push_result(lob_pkg::KIND_FILL, id_next - 1, book[os][b].id, book[os][b].price,
                    {8'd0, fill});
        book[os][b].qty -= fill;
        left -= fill;
        if (book[os][b].qty == 0) book[os][b].valid = 1'b0;
      end
      if (left != 0) begin
        slot = -1;
        for (int i = lob_pkg::BOOK_DEPTH - 1; i >= 0; i--)
          if (!book[it.side][i].valid) slot = i;
        if (slot >= 0) begin
          book[it.side][slot] = '{1'b1, it.limit_price, left, it.arrival_time, id_next - 1};
          push_result(lob_pkg::KIND_RESTED, id_next - 1, '0, it.limit_price, {8'd0, left});
        end else begin
          push_result(lob_pkg::KIND_REJECT, id_next - 1, '0, it.limit_price, {8'd0, left});
        end
      end
    end else begin
      have_prev = 1'b0; prev = '0;
      cnt = it.level_count > lob_pkg::BOOK_DEPTH ? lob_pkg::BOOK_DEPTH : it.level_count;
      for (int k = 0; k < cnt; k++) begin
        found = 1'b0; lvl = '0;
        for (int i = 0; i < lob_pkg::BOOK_DEPTH; i++) begin
          if (!book[it.side][i].valid) continue;
          if (have_prev && !(it.side == 0 ? prev > book[it.side][i].price
                                          : prev < book[it.side][i].price)) continue;
          if (!found || (it.side == 0 ? book[it.side][i].price > lvl
                                      : book[it.side][i].price < lvl)) begin
            lvl = book[it.side][i].price; found = 1'b1;
          end
        end
        if (!found) break;
        sum = '0;
        for (int i = 0; i < lob_pkg::BOOK_DEPTH; i++)
          if (book[it.side][i].valid && book[it.side][i].price == lvl)
            sum += {8'd0, book[it.side][i].qty};
        push_result(lob_pkg::KIND_LEVEL, '0, '0, lvl, sum);
        prev = lvl; have_prev = 1'b1;
      end
      if (fills_due.size() == n0) push_result(lob_pkg::KIND_EMPTY, '0, '0, '0, '0);
    end
    if (fills_due.size() > n0) fills_due[fills_due.size() - 1].last = 1'b1;
  endfunction

  // Directed table; has_exp marks rows whose result is typed in
  typedef struct {
    lob_pkg::lob_in_t item;
    bit has_exp;
    lob_pkg::lob_out_t exp;
  } dir_row_t;
  dir_row_t dir_rows [NDIR];
  lob_pkg::lob_out_t glance_due [$];

  function automatic lob_pkg::lob_in_t mk_item(bit f, bit s, logic [31:0] p, logic [31:0] q,
                                               logic [47:0] t, logic [5:0] c);
    lob_pkg::lob_in_t it;
    it.func = f; it.side = s; it.limit_price = p; it.order_qty = q;
    it.arrival_time = t; it.level_count = c;
    return it;
  endfunction

  initial begin
    lob_pkg::lob_out_t emp;
    emp = '{lob_pkg::KIND_EMPTY, 32'd0, 32'd0, 32'd0, 40'd0, 1'b1};
    dir_rows[0]  = '{mk_item(1, 0, 0, 0, 0, 6'd1), 1, emp};   // empty bid book
    dir_rows[1]  = '{mk_item(1, 1, '1, '1, '1, 6'd63), 1, emp}; // empty ask book, top bits
    dir_rows[2]  = '{mk_item(0, 0, 100, 0, 5, 0), 0, emp};     // zero quantity order
    dir_rows[3]  = '{mk_item(0, 0, '1, '1, '1, 0), 1,
                     '{lob_pkg::KIND_RESTED, 32'd1, 32'd0, 32'hffffffff, 40'hffffffff, 1'b1}};
    dir_rows[4]  = '{mk_item(0, 0, 100, 10, 20, 0), 0, emp};
    dir_rows[5]  = '{mk_item(0, 0, 100, 7, 10, 0), 0, emp};    // earlier time, same price
    dir_rows[6]  = '{mk_item(0, 0, 100, 3, 10, 0), 0, emp};    // same time, later id
    dir_rows[7]  = '{mk_item(1, 0, 0, 0, 0, 6'd32), 0, emp};
    dir_rows[8]  = '{mk_item(1, 0, 0, 0, 0, 6'd0), 1, emp};    // zero levels asked
    dir_rows[9]  = '{mk_item(0, 1, 0, 30, 0, 0), 0, emp};      // fills against the best bid only
    dir_rows[10] = '{mk_item(0, 1, 0, 40, 1, 0), 0, emp};
    dir_rows[11] = '{mk_item(0, 1, 200, 5, 2, 0), 0, emp};
    dir_rows[12] = '{mk_item(0, 1, 150, 5, 3, 0), 0, emp};
    dir_rows[13] = '{mk_item(0, 0, 180, 8, 4, 0), 0, emp};
    dir_rows[14] = '{mk_item(1, 1, 0, 0, 0, 6'd1), 0, emp};
    dir_rows[15] = '{mk_item(1, 1, 0, 0, 0, 6'd40), 0, emp};
    dir_rows[16] = '{mk_item(0, 0, 0, 1, 0, 0), 0, emp};
    dir_rows[17] = '{mk_item(0, 1, 1, 2, 0, 0), 0, emp};
    dir_rows[18] = '{mk_item(0, 0, 'h55555555, 'haaaaaaaa, 'haaaaaaaaaaa, 0), 0, emp};
    dir_rows[19] = '{mk_item(1, 0, 0, 0, 0, 6'd2), 0, emp};
  end

  // Sender: directed rows, a book-full burst, then random orders and queries
  task automatic send_item(lob_pkg::lob_in_t it);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    book_apply(it);
  endtask

  function automatic lob_pkg::lob_in_t rand_item(logic [31:0] base);
    lob_pkg::lob_in_t it;
    logic [127:0] rbits;
    rbits = {$urandom, $urandom, $urandom, $urandom};
    it = rbits[119:0];
    it.func = ($urandom_range(0, 5) == 0);
    it.side = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 7) != 0) begin
      it.limit_price = base + $urandom_range(0, 15);
      it.order_qty = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 30);
      it.arrival_time = 48'($urandom_range(0, 40));
    end
    it.level_count = 6'($urandom_range(0, 63));
    return it;
  endfunction

  initial begin
    logic [31:0] base;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < NDIR; r++) begin
      if (dir_rows[r].has_exp) glance_due = {glance_due, dir_rows[r].exp};
      send_item(dir_rows[r].item);
    end
    // Fill the bid book past capacity with low-priced buys
    for (int r = 0; r < 36; r++)
      send_item(mk_item(0, 0, $urandom_range(1, 50), $urandom_range(1, 9), r, 0));
    send_item(mk_item(1, 0, 0, 0, 0, 6'd32));
    base = 25;
    for (int r = 0; r < NRAND; r++) begin
      if (r == 60) hold_off = 1'b1;
      if (r % 50 == 0) base = $urandom_range(0, 3) == 0 ? 32'hfffffff0 : $urandom_range(0, 60);
      send_item(rand_item(base));
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off while the sender keeps going
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    lob_pkg::lob_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (fills_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item_o);
      end else begin
        want = fills_due.pop_front();
        if (glance_due.size() != 0 && glance_due[0] == want) void'(glance_due.pop_front());
        if (out_item_o !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: exp %p got %p", want, out_item_o);
        end
      end
    end
  end

  // Run end and timeout
  initial begin
    id_next = '0;
    foreach (book[s, i]) book[s][i] = '0;
    wait (stim_done);
    while (fills_due.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk_i);
    repeat (lob_pkg::BOOK_DEPTH + 8) @(posedge clk_i);
    if (cycles >= CYCLE_LIMIT || glance_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("limit_order_book_matcher_tb: clean");
    end else begin
      $display("limit_order_book_matcher_tb: errors");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT + 200) begin
      $display("limit_order_book_matcher_tb: errors");
      $finish;
    end
  end

endmodule
